[sv/hmte_pkg.sv]
// ----------------------------------------------------------------------------
// hmte_pkg - shared types and constants of the matrix transform engine
// Word type, opcode codes, result kinds and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package hmte_pkg;

	localparam int WORD_W            = 32;
	localparam int DIM               = 4;
	localparam int IDX_W             = 2;
	localparam int OPC_W             = 3;
	localparam int DEFAULT_FRAC_BITS = 16;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]         idx_t;

	// operation codes of an input item
	typedef enum logic [OPC_W-1:0] {
		OP_IDENTITY = 3'd0,
		OP_LOAD     = 3'd1,
		OP_COMPOSE  = 3'd2,
		OP_POINT    = 3'd3,
		OP_READ     = 3'd4
	} opcode_t;

	// result kind codes
	localparam logic KIND_POINT = 1'b0;
	localparam logic KIND_ELEM  = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;    // latch the accepted item
		logic identity;   // current matrix back to identity
		logic load;       // write one operand element
		logic mul_en;     // issue one multiply step
		idx_t step;       // step within a row or point pass
		logic src_point;  // multiply point coordinates, not a current row
		idx_t row;        // current row under compose
		logic rd_item;    // read the current row named by the item
		logic wr_row;     // write back a composed row
		logic wr_point;   // load the output register with a point
		logic wr_elem;    // load the output register with an element
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic out_free;   // output register can take a result this cycle
	} status_t;

endpackage

[sv/hmte_if.sv]
// ----------------------------------------------------------------------------
// hmte_if - item and result channels of the matrix transform engine
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface hmte_in_if;
	logic                 valid;
	logic                 ready;
	logic [2:0]           opcode;
	logic [1:0]           row_index;
	logic [1:0]           col_index;
	hmte_pkg::word_t      coef_value;
	hmte_pkg::word_t      point_x;
	hmte_pkg::word_t      point_y;
	hmte_pkg::word_t      point_z;

	modport source (
		output valid, opcode, row_index, col_index, coef_value,
		output point_x, point_y, point_z,
		input  ready
	);
	modport sink (
		input  valid, opcode, row_index, col_index, coef_value,
		input  point_x, point_y, point_z,
		output ready
	);
endinterface

interface hmte_out_if;
	logic                 valid;
	logic                 ready;
	logic                 result_kind;
	hmte_pkg::word_t      out_x;
	hmte_pkg::word_t      out_y;
	hmte_pkg::word_t      out_z;
	hmte_pkg::word_t      out_coef;

	modport source (
		output valid, result_kind, out_x, out_y, out_z, out_coef,
		input  ready
	);
	modport sink (
		input  valid, result_kind, out_x, out_y, out_z, out_coef,
		output ready
	);
endinterface

[sv/hmte_ctrl.sv]
// ----------------------------------------------------------------------------
// hmte_ctrl - controller of the matrix transform engine
// Decodes accepted items and sequences multiply steps, row write-back and
// result hand-off to the datapath.
// ----------------------------------------------------------------------------
module hmte_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid,
	input  logic [2:0]              opcode,
	output logic                    ready,
	output hmte_pkg::cmd_t          cmd,
	input  hmte_pkg::status_t       status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_FIN,
		S_READ
	} state_t;

	state_t           state_q;
	hmte_pkg::idx_t   step_q;
	hmte_pkg::idx_t   row_q;
	logic             is_point_q;
	logic             accept;
	hmte_pkg::opcode_t op;

	assign ready  = (state_q == S_IDLE);
	assign accept = valid && ready;
	assign op     = hmte_pkg::opcode_t'(opcode);

	// command decode
	always_comb begin
		cmd           = '0;
		cmd.capture   = accept;
		cmd.identity  = accept && (op == hmte_pkg::OP_IDENTITY);
		cmd.load      = accept && (op == hmte_pkg::OP_LOAD);
		cmd.mul_en    = (state_q == S_MUL);
		cmd.step      = step_q;
		cmd.src_point = is_point_q;
		cmd.row       = row_q;
		cmd.rd_item   = (state_q == S_READ);
		cmd.wr_row    = (state_q == S_FIN) && !is_point_q;
		cmd.wr_point  = (state_q == S_FIN) && is_point_q && status.out_free;
		cmd.wr_elem   = (state_q == S_READ) && status.out_free;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_q     <= '0;
			row_q      <= '0;
			is_point_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						step_q <= '0;
						row_q  <= '0;
						unique case (op)
							hmte_pkg::OP_COMPOSE: begin
								state_q    <= S_MUL;
								is_point_q <= 1'b0;
							end
							hmte_pkg::OP_POINT: begin
								state_q    <= S_MUL;
								is_point_q <= 1'b1;
							end
							hmte_pkg::OP_READ: begin
								state_q <= S_READ;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_MUL: begin
					step_q <= step_q + hmte_pkg::idx_t'(1);
					if (step_q == hmte_pkg::idx_t'(hmte_pkg::DIM - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (is_point_q) begin
						if (status.out_free) begin
							state_q <= S_IDLE;
						end
					end else if (row_q == hmte_pkg::idx_t'(hmte_pkg::DIM - 1)) begin
						state_q <= S_IDLE;
					end else begin
						row_q   <= row_q + hmte_pkg::idx_t'(1);
						step_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_READ: begin
					if (status.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// at most one write-back per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_row, cmd.wr_point, cmd.wr_elem}))
		else $error("hmte_ctrl: conflicting write-back commands");

	// a compose starts at row zero, step zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == hmte_pkg::OP_COMPOSE) |=>
		(state_q == S_MUL && step_q == '0 && row_q == '0 && !is_point_q))
		else $error("hmte_ctrl: compose did not start at row zero");

	// the last multiply step is followed by the finish cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL && step_q == hmte_pkg::idx_t'(hmte_pkg::DIM - 1)) |=>
		(state_q == S_FIN))
		else $error("hmte_ctrl: missing finish after last step");

	// compose ends after the last row is written
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_row && row_q == hmte_pkg::idx_t'(hmte_pkg::DIM - 1)) |=>
		(state_q == S_IDLE))
		else $error("hmte_ctrl: compose ran past the last row");

endmodule

[sv/hmte_dp.sv]
// ----------------------------------------------------------------------------
// hmte_dp - datapath of the matrix transform engine
// Current and operand matrices, four multiply lanes with product registers,
// accumulators with saturation, and the result output register.
// ----------------------------------------------------------------------------
module hmte_dp #(
	parameter int FRAC_BITS = hmte_pkg::DEFAULT_FRAC_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hmte_pkg::cmd_t          cmd,
	output hmte_pkg::status_t       status,
	input  hmte_pkg::idx_t          in_row,
	input  hmte_pkg::idx_t          in_col,
	input  hmte_pkg::word_t         in_coef,
	input  hmte_pkg::word_t         in_x,
	input  hmte_pkg::word_t         in_y,
	input  hmte_pkg::word_t         in_z,
	hmte_out_if.source              result
);

	localparam int DIM    = hmte_pkg::DIM;
	localparam int WORD_W = hmte_pkg::WORD_W;
	localparam int PROD_W = 2 * WORD_W;
	localparam int ACC_W  = PROD_W - FRAC_BITS + 2;

	localparam hmte_pkg::word_t ONE     = hmte_pkg::word_t'(1 << FRAC_BITS);
	localparam hmte_pkg::word_t SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam hmte_pkg::word_t SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	hmte_pkg::word_t          cur_q [DIM][DIM];
	hmte_pkg::word_t          opr_q [DIM][DIM];
	hmte_pkg::word_t          px_q, py_q, pz_q;
	hmte_pkg::idx_t           rrow_q, rcol_q;
	hmte_pkg::idx_t           rd_row;
	hmte_pkg::word_t          rowv  [DIM];
	hmte_pkg::word_t          mul_a;
	hmte_pkg::word_t          mul_b [DIM];
	logic signed [PROD_W-1:0] product_s1 [DIM];
	logic signed [ACC_W-1:0]  sp    [DIM];
	logic signed [ACC_W-1:0]  acc_q [DIM];
	logic signed [ACC_W-1:0]  total [DIM];
	logic [ACC_W-WORD_W:0]    hi    [DIM];
	hmte_pkg::word_t          sat_v [DIM];
	logic                     out_valid_q;
	logic                     kind_q;
	hmte_pkg::word_t          ox_q, oy_q, oz_q, ocoef_q;

	assign status.out_free = !out_valid_q || result.ready;

	// one row of the current matrix is read per cycle
	always_comb begin
		if (cmd.rd_item) begin
			rd_row = rrow_q;
		end else if (cmd.src_point) begin
			rd_row = cmd.step;
		end else begin
			rd_row = cmd.row;
		end
		for (int c = 0; c < DIM; c++) begin
			rowv[c] = cur_q[rd_row][c];
		end
	end

	// multiplier operands
	always_comb begin
		if (cmd.src_point) begin
			unique case (cmd.step)
				2'd0:    mul_a = px_q;
				2'd1:    mul_a = py_q;
				2'd2:    mul_a = pz_q;
				default: mul_a = ONE;   // translation row passes through unscaled
			endcase
		end else begin
			mul_a = rowv[cmd.step];
		end
		for (int c = 0; c < DIM; c++) begin
			mul_b[c] = cmd.src_point ? rowv[c] : opr_q[cmd.step][c];
		end
	end

	// shift, running sum and saturation
	always_comb begin
		for (int c = 0; c < DIM; c++) begin
			sp[c]    = {{2{product_s1[c][PROD_W-1]}}, product_s1[c][PROD_W-1:FRAC_BITS]};
			total[c] = acc_q[c] + sp[c];
			hi[c]    = total[c][ACC_W-1:WORD_W-1];
			if ((&hi[c]) || !(|hi[c])) begin
				sat_v[c] = total[c][WORD_W-1:0];
			end else if (total[c][ACC_W-1]) begin
				sat_v[c] = SAT_MIN;
			end else begin
				sat_v[c] = SAT_MAX;
			end
		end
	end

	// multiply lanes and accumulators
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			for (int c = 0; c < DIM; c++) begin
				product_s1[c] <= mul_a * mul_b[c];
			end
			if (cmd.step != '0) begin
				for (int c = 0; c < DIM; c++) begin
					acc_q[c] <= ((cmd.step == hmte_pkg::idx_t'(1)) ? '0 : acc_q[c]) + sp[c];
				end
			end
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			px_q   <= in_x;
			py_q   <= in_y;
			pz_q   <= in_z;
			rrow_q <= in_row;
			rcol_q <= in_col;
		end
	end

	// current matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < DIM; r++) begin
				for (int c = 0; c < DIM; c++) begin
					cur_q[r][c] <= (r == c) ? ONE : '0;
				end
			end
		end else if (cmd.identity) begin
			for (int r = 0; r < DIM; r++) begin
				for (int c = 0; c < DIM; c++) begin
					cur_q[r][c] <= (r == c) ? ONE : '0;
				end
			end
		end else if (cmd.wr_row) begin
			for (int c = 0; c < DIM; c++) begin
				cur_q[cmd.row][c] <= sat_v[c];
			end
		end
	end

	// operand matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < DIM; r++) begin
				for (int c = 0; c < DIM; c++) begin
					opr_q[r][c] <= (r == c) ? ONE : '0;
				end
			end
		end else if (cmd.load) begin
			opr_q[in_row][in_col] <= in_coef;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.wr_point || cmd.wr_elem) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.wr_point) begin
			kind_q  <= hmte_pkg::KIND_POINT;
			ox_q    <= sat_v[0];
			oy_q    <= sat_v[1];
			oz_q    <= sat_v[2];
			ocoef_q <= '0;
		end else if (cmd.wr_elem) begin
			kind_q  <= hmte_pkg::KIND_ELEM;
			ox_q    <= '0;
			oy_q    <= '0;
			oz_q    <= '0;
			ocoef_q <= rowv[rcol_q];
		end
	end

	assign result.valid       = out_valid_q;
	assign result.result_kind = kind_q;
	assign result.out_x       = ox_q;
	assign result.out_y       = oy_q;
	assign result.out_z       = oz_q;
	assign result.out_coef    = ocoef_q;

endmodule

[sv/homogeneous_matrix_transform_engine.sv]
// ----------------------------------------------------------------------------
// homogeneous_matrix_transform_engine - 4x4 fixed-point transform engine
// Keeps a current and an operand matrix in signed Q16.16 and transforms
// points with the row-vector convention.
// ----------------------------------------------------------------------------
// usage
//   item channel: opcode with row/col, coefficient and point x/y/z; one
//   transfer per command. result channel: one transfer for each point
//   transform (kind 0, out_x/y/z) and each element read (kind 1, out_coef).
//   identity and operand load leave the engine idle: the next item is taken in the
//   following cycle.
//   point transform: one item at a time; four multiply steps through four lanes,
//   one row of the current matrix per step, then a sum and saturate step.
//   compose: four rows of four multiply steps plus a write-back each; the
//   current matrix register file gives one row per cycle.
//   element read: the addressed element is loaded into the output register.
//   a result sits in the output register until taken; while the receiver
//   stalls, identity, load and compose items keep being taken, and a later
//   point or read waits in its final cycle until the register frees.
//   reset: both matrices return to identity, the output register empties.
// ----------------------------------------------------------------------------
module homogeneous_matrix_transform_engine #(
	parameter int FRAC_BITS = hmte_pkg::DEFAULT_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	hmte_in_if.sink     item,
	hmte_out_if.source  result
);

	hmte_pkg::cmd_t    cmd;
	hmte_pkg::status_t status;

	// controller
	hmte_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (item.valid),
		.opcode (item.opcode),
		.ready  (item.ready),
		.cmd    (cmd),
		.status (status)
	);

	// datapath
	hmte_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.in_row  (item.row_index),
		.in_col  (item.col_index),
		.in_coef (item.coef_value),
		.in_x    (item.point_x),
		.in_y    (item.point_y),
		.in_z    (item.point_z),
		.result  (result)
	);

endmodule

[tb/hmte_checker.sv]
// ----------------------------------------------------------------------------
// hmte_checker - scoreboard for the matrix transform engine
// Watches both channels, keeps its own copy of the current and operand
// matrices, predicts each point and readback result and compares them in
// order, field by field.
// ----------------------------------------------------------------------------
module hmte_checker #(
	parameter int FRAC_BITS = hmte_pkg::DEFAULT_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	hmte_in_if   item_mon,
	hmte_out_if  result_mon,
	output int   mismatches,
	output int   outstanding,
	output int   points_checked,
	output int   reads_checked,
	output int   composes_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam hmte_pkg::word_t UNIT    = hmte_pkg::word_t'(longint'(1) << FRAC_BITS);
	localparam longint WORD_MAX    = 64'sd2147483647;
	localparam longint WORD_MIN    = -64'sd2147483648;
	localparam int     PRINT_LIMIT = 40;

	typedef struct packed {
		logic            kind;
		hmte_pkg::word_t x;
		hmte_pkg::word_t y;
		hmte_pkg::word_t z;
		hmte_pkg::word_t coef;
	} result_t;

	hmte_pkg::word_t cur_m [16];
	hmte_pkg::word_t opd_m [16];
	result_t         expected_q [$];

	// full product, then arithmetic shift (floor)
	function automatic longint fx_mul(input hmte_pkg::word_t a, input hmte_pkg::word_t b);
		longint p;
		p = longint'(a) * longint'(b);
		return p >>> FRAC_BITS;
	endfunction

	function automatic hmte_pkg::word_t clamp32(input longint v);
		if (v > WORD_MAX)
			return hmte_pkg::word_t'(WORD_MAX);
		if (v < WORD_MIN)
			return hmte_pkg::word_t'(WORD_MIN);
		return hmte_pkg::word_t'(v);
	endfunction

	// row-vector convention, the homogeneous column is never read
	function automatic hmte_pkg::word_t project(input hmte_pkg::word_t x,
			input hmte_pkg::word_t y, input hmte_pkg::word_t z, input int c);
		return clamp32(fx_mul(x, cur_m[c]) + fx_mul(y, cur_m[4 + c])
			+ fx_mul(z, cur_m[8 + c]) + longint'(cur_m[12 + c]));
	endfunction

	function automatic void set_identity(input bit with_operand);
		for (int i = 0; i < 16; i++) begin
			cur_m[i] = (i % 5 == 0) ? UNIT : hmte_pkg::word_t'(0);
			if (with_operand)
				opd_m[i] = (i % 5 == 0) ? UNIT : hmte_pkg::word_t'(0);
		end
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t checker: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		int              slot;
		longint          acc;
		hmte_pkg::word_t row_new [4];
		result_t         want;
		if (!arst_n) begin
			set_identity(1'b1);
			expected_q.delete();
			mismatches     = 0;
			outstanding    = 0;
			points_checked = 0;
			reads_checked  = 0;
			composes_seen  = 0;
		end else begin
			// result side first: it always belongs to an earlier item
			if (result_mon.valid && result_mon.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("result transfer with nothing expected, kind %0d",
						result_mon.result_kind));
				end else begin
					want = expected_q.pop_front();
					if (result_mon.result_kind !== want.kind)
						report_mismatch($sformatf("result_kind got %0d want %0d",
							result_mon.result_kind, want.kind));
					if (result_mon.out_x !== want.x)
						report_mismatch($sformatf("out_x got %h want %h",
							result_mon.out_x, want.x));
					if (result_mon.out_y !== want.y)
						report_mismatch($sformatf("out_y got %h want %h",
							result_mon.out_y, want.y));
					if (result_mon.out_z !== want.z)
						report_mismatch($sformatf("out_z got %h want %h",
							result_mon.out_z, want.z));
					if (result_mon.out_coef !== want.coef)
						report_mismatch($sformatf("out_coef got %h want %h",
							result_mon.out_coef, want.coef));
					if (want.kind == hmte_pkg::KIND_POINT)
						points_checked++;
					else
						reads_checked++;
				end
			end

			// item side: update the matrices and queue what must come out
			if (item_mon.valid && item_mon.ready) begin
				slot = {item_mon.row_index, item_mon.col_index};
				case (item_mon.opcode)
					hmte_pkg::OP_IDENTITY: set_identity(1'b0);
					hmte_pkg::OP_LOAD: opd_m[slot] = item_mon.coef_value;
					hmte_pkg::OP_COMPOSE: begin
						// each row only sees its own old values
						for (int r = 0; r < 4; r++) begin
							for (int c = 0; c < 4; c++) begin
								acc = 0;
								for (int k = 0; k < 4; k++)
									acc += fx_mul(cur_m[r * 4 + k], opd_m[k * 4 + c]);
								row_new[c] = clamp32(acc);
							end
							for (int c = 0; c < 4; c++)
								cur_m[r * 4 + c] = row_new[c];
						end
						composes_seen++;
					end
					hmte_pkg::OP_POINT: begin
						want.kind = hmte_pkg::KIND_POINT;
						want.x    = project(item_mon.point_x, item_mon.point_y,
							item_mon.point_z, 0);
						want.y    = project(item_mon.point_x, item_mon.point_y,
							item_mon.point_z, 1);
						want.z    = project(item_mon.point_x, item_mon.point_y,
							item_mon.point_z, 2);
						want.coef = '0;
						expected_q.push_back(want);
					end
					hmte_pkg::OP_READ: begin
						want.kind = hmte_pkg::KIND_ELEM;
						want.x    = '0;
						want.y    = '0;
						want.z    = '0;
						want.coef = cur_m[slot];
						expected_q.push_back(want);
					end
					// spare opcodes change nothing
					default: ;
				endcase
			end
			outstanding = expected_q.size();
		end
	end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - top of the matrix transform engine test
// Drives commands with random gaps, throttles the result side at random and
// once holds it off for a long stretch; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int              FRAC            = hmte_pkg::DEFAULT_FRAC_BITS;
	localparam int              RANDOM_ITEMS    = 1650;
	localparam int              HOLD_OFF_CYCLES = 400;
	localparam int              QUIET_LIMIT     = 4000;
	localparam int              DRAIN_CYCLES    = 40;
	localparam logic [2:0]      OP_SPARE_FIRST  = 3'd5;
	localparam logic [2:0]      OP_SPARE_LAST   = 3'd7;
	localparam hmte_pkg::word_t UNIT_W          = hmte_pkg::word_t'(1 << FRAC);
	localparam hmte_pkg::word_t MAX_W           = hmte_pkg::word_t'(32'h7fffffff);
	localparam hmte_pkg::word_t MIN_W           = hmte_pkg::word_t'(32'h80000000);
	localparam hmte_pkg::word_t ALL_ONES_W      = hmte_pkg::word_t'(32'hffffffff);

	logic clk;
	logic arst_n;

	hmte_in_if  item_ch ();
	hmte_out_if result_ch ();

	int  mismatch_count;
	int  outstanding;
	int  points_checked;
	int  reads_checked;
	int  composes_seen;
	int  items_sent;
	int  spare_sent;
	int  hold_offs;
	int  quiet_cycles;
	bit  steady;
	bit  hold_off_req;

	homogeneous_matrix_transform_engine #(
		.FRAC_BITS(FRAC)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	hmte_checker #(
		.FRAC_BITS(FRAC)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_mon       (item_ch),
		.result_mon     (result_ch),
		.mismatches     (mismatch_count),
		.outstanding    (outstanding),
		.points_checked (points_checked),
		.reads_checked  (reads_checked),
		.composes_seen  (composes_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// mostly short gaps, a few long ones, none while steady
	function automatic int pick_gap();
		int pick;
		if (steady)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic hmte_pkg::word_t any_word();
		return hmte_pkg::word_t'($urandom());
	endfunction

	function automatic hmte_pkg::word_t edge_word();
		case ($urandom_range(0, 5))
			0: return MAX_W;
			1: return MIN_W;
			2: return '0;
			3: return ALL_ONES_W;
			4: return UNIT_W;
			default: return -UNIT_W;
		endcase
	endfunction

	// coordinates: mostly within +-256.0, some full range, some extremes
	function automatic hmte_pkg::word_t coord_word();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return hmte_pkg::word_t'(int'($urandom_range(0, 33554431)) - 16777216);
		if (pick < 85)
			return any_word();
		return edge_word();
	endfunction

	// matrix entries: mostly within +-2.0 or near 1.0, so composes stay meaningful
	function automatic hmte_pkg::word_t coef_word();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return hmte_pkg::word_t'(int'($urandom_range(0, 4 * UNIT_W)) - 2 * UNIT_W);
		if (pick < 70)
			return hmte_pkg::word_t'(int'($urandom_range(0, 8192)) - 4096 + UNIT_W);
		if (pick < 88)
			return any_word();
		return edge_word();
	endfunction

	// one command transfer, valid held until ready
	task automatic send_item(input logic [2:0] op, input hmte_pkg::idx_t r,
			input hmte_pkg::idx_t c, input hmte_pkg::word_t coef,
			input hmte_pkg::word_t x, input hmte_pkg::word_t y, input hmte_pkg::word_t z);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.opcode     <= op;
		item_ch.row_index  <= r;
		item_ch.col_index  <= c;
		item_ch.coef_value <= coef;
		item_ch.point_x    <= x;
		item_ch.point_y    <= y;
		item_ch.point_z    <= z;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		if (op <= hmte_pkg::OP_READ)
			items_sent++;
		else
			spare_sent++;
	endtask

	// result side: random throttle, plus the long hold-off on request
	initial begin
		int high_len;
		int low_len;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				hold_offs++;
			end else begin
				result_ch.ready <= 1'b1;
				high_len = $urandom_range(1, 12);
				repeat (high_len) @(posedge clk);
				low_len = pick_gap();
				if (low_len > 0) begin
					result_ch.ready <= 1'b0;
					repeat (low_len) @(posedge clk);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready)
				|| (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int random_start;
		int scenario;
		int count;
		int slot;
		arst_n             = 1'b0;
		item_ch.valid      = 1'b0;
		item_ch.opcode     = hmte_pkg::OP_IDENTITY;
		item_ch.row_index  = '0;
		item_ch.col_index  = '0;
		item_ch.coef_value = '0;
		item_ch.point_x    = '0;
		item_ch.point_y    = '0;
		item_ch.point_z    = '0;
		steady             = 1'b0;
		hold_off_req       = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset contents, extremes, the homogeneous column, spare opcodes
		send_item(hmte_pkg::OP_READ, 2'd0, 2'd0, any_word(), any_word(), any_word(),
			any_word());
		send_item(hmte_pkg::OP_READ, 2'd3, 2'd3, any_word(), any_word(), any_word(),
			any_word());
		send_item(hmte_pkg::OP_POINT, 2'd1, 2'd2, any_word(), MAX_W, MIN_W, '0);
		send_item(hmte_pkg::OP_POINT, 2'd2, 2'd1, any_word(), MIN_W, MAX_W, ALL_ONES_W);
		send_item(hmte_pkg::OP_LOAD, 2'd0, 2'd0, MAX_W, any_word(), any_word(), any_word());
		send_item(hmte_pkg::OP_LOAD, 2'd3, 2'd0, MIN_W, any_word(), any_word(), any_word());
		send_item(hmte_pkg::OP_LOAD, 2'd1, 2'd3, 3 * UNIT_W, any_word(), any_word(),
			any_word());
		send_item(hmte_pkg::OP_COMPOSE, 2'd0, 2'd0, any_word(), any_word(), any_word(),
			any_word());
		send_item(hmte_pkg::OP_READ, 2'd0, 2'd0, any_word(), any_word(), any_word(),
			any_word());
		send_item(hmte_pkg::OP_READ, 2'd1, 2'd3, any_word(), any_word(), any_word(),
			any_word());
		send_item(hmte_pkg::OP_READ, 2'd3, 2'd0, any_word(), any_word(), any_word(),
			any_word());
		send_item(hmte_pkg::OP_POINT, 2'd0, 2'd0, any_word(), MAX_W, MAX_W, MAX_W);
		send_item(hmte_pkg::OP_POINT, 2'd0, 2'd0, any_word(), MIN_W, MIN_W, MIN_W);
		send_item(OP_SPARE_FIRST, 2'd3, 2'd3, MAX_W, MAX_W, MAX_W, MAX_W);
		send_item(OP_SPARE_LAST, 2'd0, 2'd0, MIN_W, MIN_W, MIN_W, MIN_W);
		send_item(hmte_pkg::OP_IDENTITY, 2'd2, 2'd2, any_word(), any_word(), any_word(),
			any_word());
		send_item(hmte_pkg::OP_POINT, 2'd0, 2'd0, any_word(), UNIT_W + UNIT_W / 2, -UNIT_W,
			'0);
		send_item(hmte_pkg::OP_COMPOSE, 2'd0, 2'd0, any_word(), any_word(), any_word(),
			any_word());
		send_item(hmte_pkg::OP_READ, 2'd3, 2'd3, any_word(), any_word(), any_word(),
			any_word());
		send_item(hmte_pkg::OP_LOAD, 2'd2, 2'd2, ALL_ONES_W, any_word(), any_word(),
			any_word());
		send_item(hmte_pkg::OP_COMPOSE, 2'd0, 2'd0, any_word(), any_word(), any_word(),
			any_word());
		send_item(hmte_pkg::OP_READ, 2'd2, 2'd2, any_word(), any_word(), any_word(),
			any_word());
		send_item(hmte_pkg::OP_POINT, 2'd0, 2'd0, any_word(), ALL_ONES_W, ALL_ONES_W,
			ALL_ONES_W);

		// random sequences, with one long result hold-off early on
		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				steady = ~steady;
			if (hold_offs == 0 && !hold_off_req && items_sent - random_start > 200) begin
				// sender keeps offering while the result side is held off
				hold_off_req = 1'b1;
				steady       = 1'b1;
				for (int i = 0; i < 16; i++)
					send_item(i % 3 == 0 ? hmte_pkg::OP_LOAD
						: (i % 3 == 1 ? hmte_pkg::OP_POINT : hmte_pkg::OP_READ),
						hmte_pkg::idx_t'($urandom_range(0, 3)),
						hmte_pkg::idx_t'($urandom_range(0, 3)),
						coef_word(), coord_word(), coord_word(), coord_word());
				steady = 1'b0;
			end
			scenario = $urandom_range(0, 99);
			if (scenario < 45) begin
				// burst of points
				count = $urandom_range(1, 8);
				repeat (count)
					send_item(hmte_pkg::OP_POINT, hmte_pkg::idx_t'($urandom_range(0, 3)),
						hmte_pkg::idx_t'($urandom_range(0, 3)), any_word(),
						coord_word(), coord_word(), coord_word());
			end else if (scenario < 65) begin
				// build an operand, compose, then use the result
				if ($urandom_range(0, 1))
					send_item(hmte_pkg::OP_IDENTITY, hmte_pkg::idx_t'($urandom_range(0, 3)),
						hmte_pkg::idx_t'($urandom_range(0, 3)), any_word(),
						any_word(), any_word(), any_word());
				count = $urandom_range(1, 16);
				repeat (count)
					send_item(hmte_pkg::OP_LOAD, hmte_pkg::idx_t'($urandom_range(0, 3)),
						hmte_pkg::idx_t'($urandom_range(0, 3)), coef_word(),
						any_word(), any_word(), any_word());
				count = $urandom_range(1, 2);
				repeat (count)
					send_item(hmte_pkg::OP_COMPOSE, hmte_pkg::idx_t'($urandom_range(0, 3)),
						hmte_pkg::idx_t'($urandom_range(0, 3)), any_word(),
						any_word(), any_word(), any_word());
				count = $urandom_range(1, 4);
				repeat (count)
					send_item(hmte_pkg::OP_POINT, hmte_pkg::idx_t'($urandom_range(0, 3)),
						hmte_pkg::idx_t'($urandom_range(0, 3)), any_word(),
						coord_word(), coord_word(), coord_word());
			end else if (scenario < 80) begin
				// element readbacks
				count = $urandom_range(1, 4);
				repeat (count)
					send_item(hmte_pkg::OP_READ, hmte_pkg::idx_t'($urandom_range(0, 3)),
						hmte_pkg::idx_t'($urandom_range(0, 3)), any_word(),
						any_word(), any_word(), any_word());
			end else if (scenario < 88) begin
				send_item(hmte_pkg::OP_IDENTITY, hmte_pkg::idx_t'($urandom_range(0, 3)),
					hmte_pkg::idx_t'($urandom_range(0, 3)), any_word(),
					any_word(), any_word(), any_word());
				send_item(hmte_pkg::OP_POINT, hmte_pkg::idx_t'($urandom_range(0, 3)),
					hmte_pkg::idx_t'($urandom_range(0, 3)), any_word(),
					coord_word(), coord_word(), coord_word());
			end else if (scenario < 95) begin
				// noise: any opcode, spare ones included, with random fields
				count = $urandom_range(1, 4);
				repeat (count)
					send_item(3'($urandom_range(hmte_pkg::OP_IDENTITY, OP_SPARE_LAST)),
						hmte_pkg::idx_t'($urandom_range(0, 3)),
						hmte_pkg::idx_t'($urandom_range(0, 3)),
						any_word(), any_word(), any_word(), any_word());
			end else begin
				// full operand load then compose
				for (slot = 0; slot < 16; slot++)
					send_item(hmte_pkg::OP_LOAD, hmte_pkg::idx_t'(slot >> 2),
						hmte_pkg::idx_t'(slot & 3), coef_word(),
						any_word(), any_word(), any_word());
				send_item(hmte_pkg::OP_COMPOSE, hmte_pkg::idx_t'($urandom_range(0, 3)),
					hmte_pkg::idx_t'($urandom_range(0, 3)), any_word(),
					any_word(), any_word(), any_word());
			end
		end

		// drain: let the checker see the last transfer before waiting on it
		item_ch.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d commands plus %0d spare opcodes, %0d points and %0d reads checked",
			items_sent, spare_sent, points_checked, reads_checked);
		$display("summary: %0d composes, %0d long result hold-offs, %0d mismatches",
			composes_seen, hold_offs, mismatch_count);
		if (mismatch_count == 0 && outstanding == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
